@@ rtl/xst_pkg.sv @@
`timescale 1ns / 1ps
package xst_pkg;

   localparam int StateWidth = 5;

   localparam logic [4:0] ST_IDLE       = 5'd0;
   localparam logic [4:0] ST_TEXT       = 5'd1;
   localparam logic [4:0] ST_LT         = 5'd2;
   localparam logic [4:0] ST_PI         = 5'd3;
   localparam logic [4:0] ST_PI_Q       = 5'd4;
   localparam logic [4:0] ST_STAG_NAME  = 5'd5;
   localparam logic [4:0] ST_STAG_SLASH = 5'd6;
   localparam logic [4:0] ST_STAG_WS    = 5'd7;
   localparam logic [4:0] ST_ANAME      = 5'd8;
   localparam logic [4:0] ST_ANAME_WS   = 5'd9;
   localparam logic [4:0] ST_AVAL_PRE   = 5'd10;
   localparam logic [4:0] ST_AVAL       = 5'd11;
   localparam logic [4:0] ST_ENT_START  = 5'd12;
   localparam logic [4:0] ST_ENT_NAME   = 5'd13;
   localparam logic [4:0] ST_ETAG_START = 5'd14;
   localparam logic [4:0] ST_ETAG_NAME  = 5'd15;
   localparam logic [4:0] ST_ETAG_WS    = 5'd16;
   localparam logic [4:0] ST_ERR        = 5'd17;
   localparam logic [4:0] ST_DONE       = 5'd18;

   localparam logic [2:0] KIND_NONE  = 3'd0;
   localparam logic [2:0] KIND_TEXT  = 3'd1;
   localparam logic [2:0] KIND_START = 3'd2;
   localparam logic [2:0] KIND_END   = 3'd3;
   localparam logic [2:0] KIND_PI    = 3'd4;
   localparam logic [2:0] KIND_DOC   = 3'd5;

   localparam logic [2:0] ROLE_DELIM = 3'd0;
   localparam logic [2:0] ROLE_NAME  = 3'd1;
   localparam logic [2:0] ROLE_ANAME = 3'd2;
   localparam logic [2:0] ROLE_VALUE = 3'd3;
   localparam logic [2:0] ROLE_TEXT  = 3'd4;
   localparam logic [2:0] ROLE_PI    = 3'd5;

   localparam logic [3:0] ERR_NONE       = 4'd0;
   localparam logic [3:0] ERR_CDATA_END  = 4'd1;
   localparam logic [3:0] ERR_BANG       = 4'd2;
   localparam logic [3:0] ERR_NAME_START = 4'd3;
   localparam logic [3:0] ERR_TAG_CHAR   = 4'd4;
   localparam logic [3:0] ERR_SLASH      = 4'd5;
   localparam logic [3:0] ERR_ATTR_NAME  = 4'd6;
   localparam logic [3:0] ERR_EQUALS     = 4'd7;
   localparam logic [3:0] ERR_QUOTE      = 4'd8;
   localparam logic [3:0] ERR_LT_VALUE   = 4'd9;
   localparam logic [3:0] ERR_ENT_CHAR   = 4'd10;
   localparam logic [3:0] ERR_ENT_UNKNOWN = 4'd11;
   localparam logic [3:0] ERR_ETAG_CHAR  = 4'd12;
   localparam logic [3:0] ERR_EARLY_END  = 4'd13;

   localparam logic [31:0] ENT_AMP  = 32'h00616d70;
   localparam logic [31:0] ENT_LT   = 32'h00006c74;
   localparam logic [31:0] ENT_GT   = 32'h00006774;
   localparam logic [31:0] ENT_APOS = 32'h61706f73;
   localparam logic [31:0] ENT_QUOT = 32'h71756f74;

   function automatic logic is_ws(input logic [7:0] c);
      return c == 8'h20 || c == 8'h0a || c == 8'h0d || c == 8'h09;
   endfunction

   function automatic logic is_name_start(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) ||
             c == 8'h3a || c == 8'h5f;
   endfunction

   function automatic logic is_name_char(input logic [7:0] c);
      return is_name_start(c) || c == 8'h2d || c == 8'h2e ||
             (c >= 8'h30 && c <= 8'h39);
   endfunction

endpackage

@@ rtl/xml_stream_tokenizer.sv @@
`timescale 1ns / 1ps
// A result is held in the result register from the cycle after its byte is accepted.
// Throughput: one byte per cycle; the parse state update is a single short decode step.
// The result register only stalls the input when it is full and not being taken.
// Reset (synchronous, active high) returns the parser to document start, clears
// the entity buffer, bracket count and sticky error, and empties the result register.
module xml_stream_tokenizer
   import xst_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_last_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_token_kind,
   output logic       rsp_token_begin,
   output logic [2:0] rsp_byte_role,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_out_valid,
   output logic       rsp_attr_done,
   output logic       rsp_tag_closed,
   output logic       rsp_self_closing,
   output logic       rsp_end_document,
   output logic [3:0] rsp_error_code
);

   // Parser state.
   logic [4:0]  state_ff, state_in;
   logic [31:0] ebuf_ff, ebuf_in;
   logic [2:0]  elen_ff, elen_in;
   logic        einval_ff, einval_in;
   logic        qsingle_ff, qsingle_in;
   logic [1:0]  brk_ff, brk_in;
   logic [3:0]  sticky_ff, sticky_in;

   // Result register.
   logic        rv_ff;
   logic [2:0]  kind_ff;
   logic        begin_ff;
   logic [2:0]  role_ff;
   logic [7:0]  ob_ff;
   logic        ov_ff, ad_ff, tc_ff, sc_ff, ed_ff;
   logic [3:0]  err_ff;

   logic [2:0] kind, role;
   logic       tbeg, ov, ad, tc, sc, ed, checkend, ent_hit;
   logic [7:0] ob, c, rep;
   logic [3:0] err;
   logic       accept;

   // The result register may be refilled in the same cycle it is drained.
   assign req_ready = !rv_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign c         = req_in_byte;

   // Entity lookup on the stored name; the buffer keeps the newest byte lowest.
   always_comb begin
      ent_hit = 1'b1;
      rep     = 8'h00;
      if (elen_ff == 3'd3 && ebuf_ff[23:0] == ENT_AMP[23:0]) begin
         rep = 8'h26;
      end else if (elen_ff == 3'd2 && ebuf_ff[15:0] == ENT_LT[15:0]) begin
         rep = 8'h3c;
      end else if (elen_ff == 3'd2 && ebuf_ff[15:0] == ENT_GT[15:0]) begin
         rep = 8'h3e;
      end else if (elen_ff == 3'd4 && ebuf_ff == ENT_APOS) begin
         rep = 8'h27;
      end else if (elen_ff == 3'd4 && ebuf_ff == ENT_QUOT) begin
         rep = 8'h22;
      end else begin
         ent_hit = 1'b0;
      end
   end

   always_comb begin
      kind = KIND_NONE; tbeg = 1'b0; role = ROLE_DELIM; ob = 8'h00; ov = 1'b0;
      ad = 1'b0; tc = 1'b0; sc = 1'b0; ed = 1'b0; err = ERR_NONE;
      checkend   = 1'b1;
      state_in   = state_ff;
      ebuf_in    = ebuf_ff;
      elen_in    = elen_ff;
      einval_in  = einval_ff;
      qsingle_in = qsingle_ff;
      brk_in     = brk_ff;
      sticky_in  = sticky_ff;
      case (state_ff)
         ST_IDLE, ST_TEXT: begin
            if (c == 8'h3c) begin
               brk_in   = 2'd0;
               state_in = ST_LT;
            end else begin
               kind     = KIND_TEXT;
               role     = ROLE_TEXT;
               tbeg     = state_ff == ST_IDLE;
               state_in = ST_TEXT;
               if (c == 8'h26) begin
                  brk_in    = 2'd0;
                  einval_in = 1'b0;
                  state_in  = ST_ENT_START;
               end else if (c == 8'h5d) begin
                  if (brk_ff != 2'd2) brk_in = brk_ff + 2'd1;
                  ob = c; ov = 1'b1;
               end else if (c == 8'h3e && brk_ff == 2'd2) begin
                  err = ERR_CDATA_END;
               end else begin
                  brk_in = 2'd0;
                  ob = c; ov = 1'b1;
               end
            end
         end
         ST_LT: begin
            if (c == 8'h3f) begin
               kind = KIND_PI; tbeg = 1'b1; state_in = ST_PI;
            end else if (c == 8'h2f) begin
               kind = KIND_END; tbeg = 1'b1; state_in = ST_ETAG_START;
            end else if (c == 8'h21) begin
               err = ERR_BANG;
            end else if (is_name_start(c)) begin
               kind = KIND_START; tbeg = 1'b1; role = ROLE_NAME; ob = c; ov = 1'b1;
               state_in = ST_STAG_NAME;
            end else begin
               err = ERR_NAME_START;
            end
         end
         ST_PI, ST_PI_Q: begin
            kind = KIND_PI;
            if (state_ff == ST_PI_Q && c == 8'h3e) begin
               tc = 1'b1; state_in = ST_IDLE;
            end else begin
               role = ROLE_PI; ob = c; ov = 1'b1;
               state_in = (c == 8'h3f) ? ST_PI_Q : ST_PI;
            end
         end
         ST_STAG_NAME, ST_STAG_WS: begin
            kind = KIND_START;
            if (c == 8'h3e) begin
               tc = 1'b1; state_in = ST_IDLE;
            end else if (c == 8'h2f) begin
               state_in = ST_STAG_SLASH;
            end else if (is_ws(c)) begin
               state_in = ST_STAG_WS;
            end else if (state_ff == ST_STAG_NAME) begin
               if (is_name_char(c)) begin
                  role = ROLE_NAME; ob = c; ov = 1'b1;
               end else begin
                  err = ERR_TAG_CHAR;
               end
            end else if (is_name_start(c)) begin
               role = ROLE_ANAME; ob = c; ov = 1'b1; state_in = ST_ANAME;
            end else begin
               err = ERR_ATTR_NAME;
            end
         end
         ST_STAG_SLASH: begin
            kind = KIND_START;
            if (c == 8'h3e) begin
               tc = 1'b1; sc = 1'b1; state_in = ST_IDLE;
            end else begin
               err = ERR_SLASH;
            end
         end
         ST_ANAME: begin
            kind = KIND_START;
            if (is_name_char(c)) begin
               role = ROLE_ANAME; ob = c; ov = 1'b1;
            end else if (c == 8'h3d) begin
               state_in = ST_AVAL_PRE;
            end else if (is_ws(c)) begin
               state_in = ST_ANAME_WS;
            end else begin
               err = ERR_ATTR_NAME;
            end
         end
         ST_ANAME_WS: begin
            kind = KIND_START;
            if (c == 8'h3d) state_in = ST_AVAL_PRE;
            else if (!is_ws(c)) err = ERR_EQUALS;
         end
         ST_AVAL_PRE: begin
            kind = KIND_START;
            if (c == 8'h22 || c == 8'h27) begin
               qsingle_in = c == 8'h27;
               state_in   = ST_AVAL;
            end else if (!is_ws(c)) begin
               err = ERR_QUOTE;
            end
         end
         ST_AVAL: begin
            kind = KIND_START;
            if (c == (qsingle_ff ? 8'h27 : 8'h22)) begin
               ad = 1'b1; state_in = ST_STAG_WS;
            end else if (c == 8'h26) begin
               role = ROLE_VALUE; einval_in = 1'b1; state_in = ST_ENT_START;
            end else if (c == 8'h3c) begin
               err = ERR_LT_VALUE;
            end else begin
               role = ROLE_VALUE; ob = c; ov = 1'b1;
            end
         end
         ST_ENT_START, ST_ENT_NAME: begin
            kind = einval_ff ? KIND_START : KIND_TEXT;
            role = einval_ff ? ROLE_VALUE : ROLE_TEXT;
            if (state_ff == ST_ENT_START) begin
               if (is_name_start(c)) begin
                  ebuf_in  = {24'h000000, c};
                  elen_in  = 3'd1;
                  state_in = ST_ENT_NAME;
               end else begin
                  err = ERR_ENT_CHAR;
               end
            end else if (is_name_char(c)) begin
               ebuf_in = {ebuf_ff[23:0], c};
               if (elen_ff < 3'd5) elen_in = elen_ff + 3'd1;
            end else if (c == 8'h3b) begin
               if (ent_hit) begin
                  ob = rep; ov = 1'b1;
                  state_in = einval_ff ? ST_AVAL : ST_TEXT;
               end else begin
                  err = ERR_ENT_UNKNOWN;
               end
            end else begin
               err = ERR_ENT_CHAR;
            end
         end
         ST_ETAG_START: begin
            kind = KIND_END;
            if (is_name_start(c)) begin
               role = ROLE_NAME; ob = c; ov = 1'b1; state_in = ST_ETAG_NAME;
            end else begin
               err = ERR_NAME_START;
            end
         end
         ST_ETAG_NAME, ST_ETAG_WS: begin
            kind = KIND_END;
            if (c == 8'h3e) begin
               tc = 1'b1; state_in = ST_IDLE;
            end else if (is_ws(c)) begin
               state_in = ST_ETAG_WS;
            end else if (state_ff == ST_ETAG_NAME && is_name_char(c)) begin
               role = ROLE_NAME; ob = c; ov = 1'b1;
            end else begin
               err = ERR_ETAG_CHAR;
            end
         end
         ST_DONE: begin
            kind = KIND_DOC; checkend = 1'b0;
         end
         default: begin
            // Error state: repeat the sticky code on every byte.
            err = sticky_ff; checkend = 1'b0; state_in = ST_ERR;
         end
      endcase

      if (err == ERR_NONE && checkend && req_last_byte) begin
         if (state_in == ST_IDLE || state_in == ST_TEXT) begin
            ed = 1'b1; state_in = ST_DONE;
         end else begin
            err = ERR_EARLY_END;
         end
      end
      if (err != ERR_NONE) begin
         sticky_in = err;
         state_in  = ST_ERR;
         kind = KIND_NONE; tbeg = 1'b0; role = ROLE_DELIM; ob = 8'h00; ov = 1'b0;
         ad = 1'b0; tc = 1'b0; sc = 1'b0; ed = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         ebuf_ff    <= 32'h0;
         elen_ff    <= 3'd0;
         einval_ff  <= 1'b0;
         qsingle_ff <= 1'b0;
         brk_ff     <= 2'd0;
         sticky_ff  <= ERR_NONE;
         rv_ff      <= 1'b0;
      end else begin
         if (accept) begin
            state_ff   <= state_in;
            ebuf_ff    <= ebuf_in;
            elen_ff    <= elen_in;
            einval_ff  <= einval_in;
            qsingle_ff <= qsingle_in;
            brk_ff     <= brk_in;
            sticky_ff  <= sticky_in;
            rv_ff      <= 1'b1;
         end else if (rsp_ready) begin
            rv_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff  <= kind;
         begin_ff <= tbeg;
         role_ff  <= role;
         ob_ff    <= ob;
         ov_ff    <= ov;
         ad_ff    <= ad;
         tc_ff    <= tc;
         sc_ff    <= sc;
         ed_ff    <= ed;
         err_ff   <= err;
      end
   end

   assign rsp_valid        = rv_ff;
   assign rsp_token_kind   = kind_ff;
   assign rsp_token_begin  = begin_ff;
   assign rsp_byte_role    = role_ff;
   assign rsp_out_byte     = ob_ff;
   assign rsp_out_valid    = ov_ff;
   assign rsp_attr_done    = ad_ff;
   assign rsp_tag_closed   = tc_ff;
   assign rsp_self_closing = sc_ff;
   assign rsp_end_document = ed_ff;
   assign rsp_error_code   = err_ff;

endmodule

@@ rtl/xst_checker.sv @@
`timescale 1ns / 1ps
module xst_checker
   import xst_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_token_kind,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_out_valid,
   input logic       rsp_self_closing,
   input logic       rsp_tag_closed,
   input logic [3:0] rsp_error_code
);

   // An error result carries nothing else.
   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code != ERR_NONE |->
         rsp_token_kind == KIND_NONE && !rsp_out_valid && rsp_out_byte == 8'h00)
      else $error("error result has other fields set");

   a_sc_closes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_self_closing |-> rsp_tag_closed)
      else $error("self closing without tag close");

   // An accepted byte always yields a result on the next cycle.
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted byte gave no result");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte))
      else $error("stalled result changed");

endmodule

bind xml_stream_tokenizer xst_checker u_xst_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_token_kind(rsp_token_kind),
   .rsp_out_byte(rsp_out_byte), .rsp_out_valid(rsp_out_valid),
   .rsp_self_closing(rsp_self_closing), .rsp_tag_closed(rsp_tag_closed),
   .rsp_error_code(rsp_error_code)
);
